// ----- rtl/core/blid_pkg.sv -----
`timescale 1ns / 1ps

package blid_pkg;

   localparam int DEFAULT_CAPACITY = 32;
   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      REQ_PUSH_FRONT = 2'd0,
      REQ_APPEND     = 2'd1,
      REQ_DELETE     = 2'd2,
      REQ_NOP        = 2'd3
   } req_kind_type;

   // What every cell does with its value
   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_APPEND,
      CELL_DELETE,
      CELL_ROTATE
   } cell_cmd_type;

   typedef struct packed {
      logic [1:0]                 req_type;
      logic signed [VALUE_W-1:0]  item_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  elem_value;
      logic                       is_last;
      logic                       list_empty;
      logic                       insert_dropped;
   } rsp_payload_type;

endpackage

// ----- rtl/core/bounded_list_insert_delete_unit.sv -----
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values, held in a row of CAPACITY cells.
// Request: drive req_payload and raise start; the request is taken at a clock
// edge where start is high and busy is low. Kinds: push at front, append at
// back, delete at position (negative position deletes index 1, positions past
// the end change nothing), no change.
// The list edit happens in the accept cycle, in all cells at once.
// Response: starting the cycle after accept, the whole list is sent front to
// back, one beat per cycle on rsp_payload with rsp_strobe high; is_last marks
// the final beat. An empty list gives one beat with list_empty set. An insert
// into a full list is dropped and every beat of that request has insert_dropped.
// The list holds up to CAPACITY elements. The beats come from cell 0 while the
// cell row rotates by one position per beat, so the element count sets the
// length of the response.
// busy stays high while beats go out. The receiver cannot stall: each beat is
// valid for one cycle only. Reset empties the list and returns to idle.
module bounded_list_insert_delete_unit #(
   parameter int CAPACITY = blid_pkg::DEFAULT_CAPACITY
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  blid_pkg::req_payload_type req_payload,
   output logic                      rsp_strobe,
   output blid_pkg::rsp_payload_type rsp_payload
);
   import blid_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(CAPACITY);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] beat_ff, beat_in;
   logic             dropped_ff, dropped_in;

   logic                      accept;
   logic                      full;
   logic                      last_beat;
   logic [VALUE_W-1:0]        del_pos;
   logic                      del_ok;
   logic [CNT_W-1:0]          pos;
   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] values [CAPACITY];

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign full   = (count_ff == FULL);

   assign del_pos = req_payload.item_value[VALUE_W-1] ? VALUE_W'(1)
                                                      : req_payload.item_value;
   assign del_ok  = (del_pos < VALUE_W'(count_ff));
   assign pos     = del_pos[CNT_W-1:0];

   assign last_beat = (count_ff == '0) || (CNT_W'(beat_ff + 1'b1) == count_ff);

   always_comb begin
      cmd        = CELL_HOLD;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         dropped_in = 1'b0;
         case (req_payload.req_type)
            REQ_PUSH_FRONT, REQ_APPEND: begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  cmd      = (req_payload.req_type == REQ_PUSH_FRONT) ? CELL_PUSH
                                                                      : CELL_APPEND;
                  count_in = count_ff + 1'b1;
               end
            end
            REQ_DELETE: begin
               if (del_ok) begin
                  cmd      = CELL_DELETE;
                  count_in = count_ff - 1'b1;
               end
            end
            default: cmd = CELL_HOLD;
         endcase
      end else if (state_ff == ST_EMIT && count_ff != '0) begin
         cmd = CELL_ROTATE;
      end
   end

   always_comb begin
      state_in = state_ff;
      beat_in  = beat_ff;
      case (state_ff)
         ST_IDLE: begin
            beat_in = '0;
            if (accept) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (last_beat) begin
               state_in = ST_IDLE;
               beat_in  = '0;
            end else begin
               beat_in = beat_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
            beat_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         beat_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         beat_ff    <= beat_in;
         dropped_ff <= dropped_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [VALUE_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid
         assign left_v = values[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
         assign right_v = '0;
      end else begin : g_body
         assign right_v = values[i+1];
      end
      blid_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .pos         (pos),
         .new_value   (req_payload.item_value),
         .left_value  (left_v),
         .right_value (right_v),
         .head_value  (values[0]),
         .value       (values[i])
      );
   end

   assign rsp_strobe                 = (state_ff == ST_EMIT);
   assign rsp_payload.elem_value     = (count_ff == '0) ? '0 : values[0];
   assign rsp_payload.is_last        = last_beat;
   assign rsp_payload.list_empty     = (count_ff == '0);
   assign rsp_payload.insert_dropped = dropped_ff;

endmodule

// ----- rtl/core/blid_cell.sv -----
`timescale 1ns / 1ps

module blid_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 6
) (
   input  logic                                clock,
   input  blid_pkg::cell_cmd_type              cmd,
   input  logic [CNT_W-1:0]                    count,
   input  logic [CNT_W-1:0]                    pos,
   input  logic signed [blid_pkg::VALUE_W-1:0] new_value,
   input  logic signed [blid_pkg::VALUE_W-1:0] left_value,
   input  logic signed [blid_pkg::VALUE_W-1:0] right_value,
   input  logic signed [blid_pkg::VALUE_W-1:0] head_value,
   output logic signed [blid_pkg::VALUE_W-1:0] value
);
   import blid_pkg::*;

   localparam logic [CNT_W-1:0] IDX      = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_NEXT = CNT_W'(INDEX + 1);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd)
         CELL_PUSH: begin
            value_in = (IDX == '0) ? new_value : left_value;
         end
         CELL_APPEND: begin
            if (IDX == count) value_in = new_value;
         end
         CELL_DELETE: begin
            if (IDX >= pos) value_in = right_value;
         end
         CELL_ROTATE: begin
            // the tail slot takes the head so the list comes back in place
            value_in = (IDX_NEXT == count) ? head_value : right_value;
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ----- tb/bounded_list_insert_delete_unit_tb.sv -----
`timescale 1ns / 1ps

module bounded_list_insert_delete_unit_tb;
   import blid_pkg::*;

   localparam int LIST_CAP        = DEFAULT_CAPACITY;
   localparam int RANDOM_REQUESTS = 110;

   // Tracks the list contents and the beats each accepted request should produce.
   class list_scoreboard;
      logic signed [VALUE_W-1:0] held_values[$];
      rsp_payload_type           pending_beats[$];
      int                        errors;

      function int depth();
         return held_values.size();
      endfunction

      function int outstanding();
         return pending_beats.size();
      endfunction

      function void note_request(req_payload_type req);
         logic [VALUE_W-1:0] pos;
         logic               dropped;
         rsp_payload_type    beat;
         dropped = 1'b0;
         pos = req.item_value;
         case (req_kind_type'(req.req_type))
            REQ_PUSH_FRONT, REQ_APPEND: begin
               if (held_values.size() >= LIST_CAP)
                  dropped = 1'b1;
               else if (req_kind_type'(req.req_type) == REQ_PUSH_FRONT)
                  held_values.push_front(req.item_value);
               else
                  held_values.push_back(req.item_value);
            end
            REQ_DELETE: begin
               // a negative position removes the second element
               if (pos[VALUE_W-1])
                  pos = 1;
               if (pos < held_values.size())
                  held_values.delete(int'(pos));
            end
            default: ;
         endcase
         if (held_values.size() == 0) begin
            beat = '{elem_value: '0, is_last: 1'b1, list_empty: 1'b1,
                     insert_dropped: dropped};
            pending_beats.push_back(beat);
         end
         foreach (held_values[i]) begin
            beat = '{elem_value: held_values[i],
                     is_last: (i == held_values.size() - 1),
                     list_empty: 1'b0, insert_dropped: dropped};
            pending_beats.push_back(beat);
         end
      endfunction

      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat: value %0d last %b empty %b dropped %b",
                     $time, got.elem_value, got.is_last, got.list_empty,
                     got.insert_dropped);
            errors++;
            return;
         end
         want = pending_beats.pop_front();
         if (got !== want) begin
            $display("%0t: beat mismatch: expected value %0d last %b empty %b dropped %b",
                     $time, want.elem_value, want.is_last, want.list_empty,
                     want.insert_dropped);
            $display("%0t:                  actual value %0d last %b empty %b dropped %b",
                     $time, got.elem_value, got.is_last, got.list_empty,
                     got.insert_dropped);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   req_payload_type req_payload;
   logic            rsp_strobe;
   rsp_payload_type rsp_payload;

   list_scoreboard board;
   int             burst_left = 0;

   bounded_list_insert_delete_unit #(
      .CAPACITY(LIST_CAP)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         board.check_beat(rsp_payload);
   end

   task automatic idle(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold start high until the block takes the request, then log it.
   task automatic send_request(req_payload_type req);
      req_payload <= req;
      start <= 1'b1;
      do
         @(posedge clock);
      while (busy);
      board.note_request(req);
   endtask

   task automatic issue(req_kind_type kind, logic signed [VALUE_W-1:0] value);
      int gap;
      req_payload_type req;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0)
            idle(gap);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                  : $urandom_range(1, 6);
      end
      burst_left--;
      req.req_type = kind;
      req.item_value = value;
      send_request(req);
   endtask

   initial begin
      req_kind_type              kind;
      logic signed [VALUE_W-1:0] value;
      int                        roll;
      int                        fill;
      int                        full_hits;
      int                        waited;
      bit                        growing;

      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list, single element, negative and out-of-range deletes
      issue(REQ_NOP, 0);
      issue(REQ_DELETE, 0);
      issue(REQ_DELETE, -1);
      issue(REQ_PUSH_FRONT, 32'sh7FFF_FFFF);
      issue(REQ_DELETE, -5);
      issue(REQ_DELETE, 1);
      issue(REQ_APPEND, 32'sh8000_0000);
      issue(REQ_PUSH_FRONT, 0);
      issue(REQ_PUSH_FRONT, -1);
      issue(REQ_DELETE, 32'sh8000_0000);
      issue(REQ_DELETE, 32'sh7FFF_FFFF);
      issue(REQ_DELETE, 3);
      issue(REQ_DELETE, 2);
      issue(REQ_DELETE, 0);
      issue(REQ_NOP, 0);
      issue(REQ_APPEND, 32'sh5555_5555);
      issue(REQ_APPEND, 32'shAAAA_AAAA);
      issue(REQ_DELETE, 1);
      issue(REQ_DELETE, 0);
      issue(REQ_DELETE, 0);

      // alternate between filling the list past full and draining it
      growing = 1'b1;
      full_hits = 0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         roll = $urandom_range(0, 99);
         fill = board.depth();
         if (fill == LIST_CAP)
            full_hits++;
         if (growing && full_hits >= 4) begin
            growing = 1'b0;
            full_hits = 0;
         end else if (!growing && fill == 0) begin
            growing = 1'b1;
         end

         if (growing) begin
            if (roll < 45)
               kind = REQ_PUSH_FRONT;
            else if (roll < 80)
               kind = REQ_APPEND;
            else if (roll < 90)
               kind = REQ_DELETE;
            else
               kind = REQ_NOP;
         end else begin
            if (roll < 70)
               kind = REQ_DELETE;
            else if (roll < 78)
               kind = REQ_PUSH_FRONT;
            else if (roll < 85)
               kind = REQ_APPEND;
            else
               kind = REQ_NOP;
         end

         if (kind == REQ_DELETE) begin
            case ($urandom_range(0, 5))
               0: value = 0;
               1: value = {1'b1, 31'($urandom)};
               2: value = fill;
               3: value = $urandom;
               default: value = (fill > 0) ? $urandom_range(0, fill - 1) : 0;
            endcase
         end else begin
            case ($urandom_range(0, 9))
               0: value = 32'sh7FFF_FFFF;
               1: value = 32'sh8000_0000;
               default: value = $urandom;
            endcase
         end
         issue(kind, value);
      end

      start <= 1'b0;
      waited = 0;
      while (board.outstanding() > 0 && waited < 4000) begin
         @(posedge clock);
         waited++;
      end
      repeat (LIST_CAP + 4) @(posedge clock);
      if (board.outstanding() > 0)
         $display("%0t: %0d expected beats never arrived", $time, board.outstanding());
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("%0t: timeout", $time);
      $display("TEST FAILED");
      $finish;
   end

endmodule
